FILE: sv/bdc_pkg.sv
package bdc_pkg;

  // Field widths
  localparam int RateW = 22;
  localparam int PselW = 3;
  localparam int ByteW = 8;

  // Quotient width covers the largest dividend (20000000 < 2**25)
  localparam int QuotW = 25;
  // One restoring-division stage per quotient bit
  localparam int NumDiv = QuotW;
  // The remainder always stays below the rate
  localparam int RemW = RateW;
  // Modulation sums: quotient + offset, then m + m/2
  localparam int ModW = QuotW + 1;
  localparam int SumW = ModW + 1;

  localparam logic [QuotW-1:0] ModNumer  = QuotW'(20000000);
  localparam logic [ModW-1:0]  ModOffset = ModW'(1100);
  localparam logic [QuotW-1:0] DivLimit  = QuotW'(8'hFF);

  // Rows of the rate table, in search order
  typedef enum logic [2:0] {
    ROW_FIX_307K,
    ROW_FIX_921K,
    ROW_CLK_6M,
    ROW_CLK_750K,
    ROW_CLK_94K,
    ROW_CLK_12K,
    ROW_NONE
  } row_e;

  // Payload of one division stage
  typedef struct packed {
    logic [RateW-1:0] rate;
    row_e             row;
    logic [RemW-1:0]  rem_b;
    logic [RemW-1:0]  rem_m;
    logic [QuotW-1:0] quo_b;
    logic [QuotW-1:0] quo_m;
  } div_stage_t;

  // Payload after the range check and rounding decision
  typedef struct packed {
    logic             err;
    row_e             row;
    logic [ByteW-1:0] q8;
    logic             rnd;
    logic [ModW-1:0]  mod;
  } fin_stage_t;

  // Result payload
  typedef struct packed {
    logic             status;
    logic [PselW-1:0] psel;
    logic [ByteW-1:0] dbyte;
    logic [ByteW-1:0] mbyte;
  } res_t;

  // First row whose range holds the rate
  function automatic row_e row_lookup(input logic [RateW-1:0] rate);
    row_e row;
    row = ROW_NONE;
    if (rate == RateW'(307200)) begin
      row = ROW_FIX_307K;
    end else if (rate == RateW'(921600)) begin
      row = ROW_FIX_921K;
    end else if (rate >= RateW'(23530) && rate <= RateW'(2999999)) begin
      row = ROW_CLK_6M;
    end else if (rate >= RateW'(2942) && rate <= RateW'(23529)) begin
      row = ROW_CLK_750K;
    end else if (rate >= RateW'(368) && rate <= RateW'(2941)) begin
      row = ROW_CLK_94K;
    end else if (rate >= RateW'(1) && rate <= RateW'(367)) begin
      row = ROW_CLK_12K;
    end
    return row;
  endfunction

  // Base clock of a row; zero for fixed and unmatched rows
  function automatic logic [QuotW-1:0] row_clock(input row_e row);
    logic [QuotW-1:0] clk;
    case (row)
      ROW_CLK_6M:   clk = QuotW'(6000000);
      ROW_CLK_750K: clk = QuotW'(750000);
      ROW_CLK_94K:  clk = QuotW'(93750);
      ROW_CLK_12K:  clk = QuotW'(11719);
      default:      clk = '0;
    endcase
    return clk;
  endfunction

  function automatic logic [PselW-1:0] row_psel(input row_e row);
    logic [PselW-1:0] psel;
    case (row)
      ROW_FIX_307K, ROW_FIX_921K: psel = PselW'(7);
      ROW_CLK_6M:                 psel = PselW'(3);
      ROW_CLK_750K:               psel = PselW'(2);
      ROW_CLK_94K:                psel = PselW'(1);
      default:                    psel = '0;
    endcase
    return psel;
  endfunction

  function automatic logic row_is_fixed(input row_e row);
    return (row == ROW_FIX_307K) || (row == ROW_FIX_921K);
  endfunction

  function automatic logic [ByteW-1:0] row_fixed_byte(input row_e row);
    logic [ByteW-1:0] fb;
    case (row)
      ROW_FIX_307K: fb = 8'hD9;
      ROW_FIX_921K: fb = 8'hF3;
      default:      fb = '0;
    endcase
    return fb;
  endfunction

endpackage

FILE: sv/baud_divider_calc_unit.sv
// Baud divider calculator.
// Request channel: rate_i with rate_valid_i / rate_ready_o. One request is
// taken at each edge where both are high.
// Result channel: status_o, prescaler_o, divisor_byte_o, modulation_byte_o
// with res_valid_o / res_ready_i; one result per request, in order.
// The rate is matched against a six-row range table, then two restoring
// dividers (base clock / rate and 20000000 / rate) run side by side, one
// quotient bit per stage over 25 stages.
// Pipeline: one input register, 25 divider stages, one range-check stage,
// one result register. Throughput: one request per cycle while the result
// side does not stall; the divider stage chain sets the latency, and every
// stage is registered, so only a stalled receiver limits the rate.
// Reset clears all stage valid bits; the pipeline comes up empty.
// When the receiver stalls, the result register holds and stages behind it
// keep filling their empty slots; rate_ready_o drops only when every stage
// is full, so nothing is lost or repeated.
module baud_divider_calc_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rate_valid_i,
  output logic                        rate_ready_o,
  input  logic [bdc_pkg::RateW-1:0]   rate_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic                        status_o,
  output logic [bdc_pkg::PselW-1:0]   prescaler_o,
  output logic [bdc_pkg::ByteW-1:0]   divisor_byte_o,
  output logic [bdc_pkg::ByteW-1:0]   modulation_byte_o
);

  // Stage registers: div 0 is the input register, div k+1 follows divider stage k
  bdc_pkg::div_stage_t div_q [bdc_pkg::NumDiv+1];
  logic [bdc_pkg::NumDiv:0] div_v_q;
  logic [bdc_pkg::NumDiv:0] div_en;
  bdc_pkg::fin_stage_t fin_q, fin_d;
  logic fin_v_q, fin_en;
  bdc_pkg::res_t res_q, res_d;
  logic res_v_q, res_en;

  // Advance a stage when it is empty or the stage after it advances
  assign res_en = !res_v_q || res_ready_i;
  assign fin_en = !fin_v_q || res_en;
  assign div_en[bdc_pkg::NumDiv] = !div_v_q[bdc_pkg::NumDiv] || fin_en;

  for (genvar k = 0; k < bdc_pkg::NumDiv; k++) begin : g_en
    assign div_en[k] = !div_v_q[k] || div_en[k+1];
  end

  assign rate_ready_o = div_en[0];

  // Input register: latch the rate and its table row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_v_q[0] <= 1'b0;
    end else if (div_en[0]) begin
      div_v_q[0] <= rate_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_en[0]) begin
      div_q[0].rate  <= rate_i;
      div_q[0].row   <= bdc_pkg::row_lookup(rate_i);
      div_q[0].rem_b <= '0;
      div_q[0].rem_m <= '0;
      div_q[0].quo_b <= '0;
      div_q[0].quo_m <= '0;
    end
  end

  // Divider stages: stage k resolves quotient bit QuotW-1-k of both divisions
  for (genvar k = 0; k < bdc_pkg::NumDiv; k++) begin : g_div
    localparam int Bit = bdc_pkg::QuotW - 1 - k;

    logic [bdc_pkg::QuotW-1:0] dvd_b;
    logic [bdc_pkg::RemW:0]    sh_b, sh_m, rate_x;
    logic                      ge_b, ge_m;
    bdc_pkg::div_stage_t       stg_d;

    always_comb begin
      dvd_b  = bdc_pkg::row_clock(div_q[k].row);
      rate_x = {1'b0, div_q[k].rate};
      sh_b   = {div_q[k].rem_b, dvd_b[Bit]};
      sh_m   = {div_q[k].rem_m, bdc_pkg::ModNumer[Bit]};
      ge_b   = sh_b >= rate_x;
      ge_m   = sh_m >= rate_x;
      stg_d       = div_q[k];
      stg_d.rem_b = bdc_pkg::RemW'(ge_b ? sh_b - rate_x : sh_b);
      stg_d.rem_m = bdc_pkg::RemW'(ge_m ? sh_m - rate_x : sh_m);
      stg_d.quo_b = {div_q[k].quo_b[bdc_pkg::QuotW-2:0], ge_b};
      stg_d.quo_m = {div_q[k].quo_m[bdc_pkg::QuotW-2:0], ge_m};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[k+1] <= 1'b0;
      end else if (div_en[k+1]) begin
        div_v_q[k+1] <= div_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (div_en[k+1]) begin
        div_q[k+1] <= stg_d;
      end
    end
  end

  // Range check, rounding decision and modulation offset
  always_comb begin
    bdc_pkg::div_stage_t last;
    last       = div_q[bdc_pkg::NumDiv];
    fin_d.row  = last.row;
    fin_d.err  = (last.row == bdc_pkg::ROW_NONE) ||
                 (!bdc_pkg::row_is_fixed(last.row) &&
                  ((last.quo_b == '0) || (last.quo_b >= bdc_pkg::DivLimit)));
    fin_d.q8   = last.quo_b[bdc_pkg::ByteW-1:0];
    fin_d.rnd  = {last.rem_b, 1'b0} >= {1'b0, last.rate};
    fin_d.mod  = bdc_pkg::ModW'(last.quo_m) + bdc_pkg::ModOffset;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (fin_en) begin
      fin_v_q <= div_v_q[bdc_pkg::NumDiv];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_en) begin
      fin_q <= fin_d;
    end
  end

  // Form the divisor byte and scaled modulation; zero all settings on error
  always_comb begin
    logic [bdc_pkg::ByteW-1:0] qr;
    logic [bdc_pkg::SumW-1:0]  sum;
    qr  = fin_q.q8 + bdc_pkg::ByteW'(fin_q.rnd);
    sum = bdc_pkg::SumW'(fin_q.mod) + bdc_pkg::SumW'(fin_q.mod >> 1);
    res_d.status = fin_q.err;
    res_d.psel   = '0;
    res_d.dbyte  = '0;
    res_d.mbyte  = '0;
    if (!fin_q.err) begin
      res_d.psel  = bdc_pkg::row_psel(fin_q.row);
      res_d.dbyte = bdc_pkg::row_is_fixed(fin_q.row) ?
                    bdc_pkg::row_fixed_byte(fin_q.row) : bdc_pkg::ByteW'(8'd0 - qr);
      res_d.mbyte = sum[2*bdc_pkg::ByteW-1:bdc_pkg::ByteW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (res_en) begin
      res_v_q <= fin_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_en) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o       = res_v_q;
  assign status_o          = res_q.status;
  assign prescaler_o       = res_q.psel;
  assign divisor_byte_o    = res_q.dbyte;
  assign modulation_byte_o = res_q.mbyte;

endmodule

FILE: sv/bdc_chk.sv
module bdc_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        rate_valid_i,
  input logic                        rate_ready_o,
  input logic [bdc_pkg::RateW-1:0]   rate_i,
  input logic                        res_valid_o,
  input logic                        res_ready_i,
  input logic                        status_o,
  input logic [bdc_pkg::PselW-1:0]   prescaler_o,
  input logic [bdc_pkg::ByteW-1:0]   divisor_byte_o,
  input logic [bdc_pkg::ByteW-1:0]   modulation_byte_o
);

  // Hold a stalled request on the input side
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rate_valid_i && !rate_ready_o |=> rate_valid_i && $stable(rate_i))
    else $error("request dropped or changed while stalled");

  // Hold a stalled result on the output side
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(status_o) &&
      $stable(prescaler_o) && $stable(divisor_byte_o) && $stable(modulation_byte_o))
    else $error("result dropped or changed while stalled");

  // Error results carry all-zero settings
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o |->
      prescaler_o == '0 && divisor_byte_o == '0 && modulation_byte_o == '0)
    else $error("error result with nonzero settings");

  // Top prescaler only comes from the fixed rows
  a_fixed_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !status_o && prescaler_o == 3'd7 |->
      divisor_byte_o == 8'hD9 || divisor_byte_o == 8'hF3)
    else $error("fixed-row prescaler with wrong divisor byte");

endmodule

bind baud_divider_calc_unit bdc_chk u_bdc_chk (.*);
